[rtl/core/psfwrl_pkg.sv]
// Shared types, constants and codes for the per-source fixed-window rate limiter.
// Used by psfwrl_ctrl, psfwrl_datapath and the top level; depends on nothing.
package psfwrl_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;

    localparam count_t    COUNT_MAX    = '1;
    localparam cfg_data_t LIMIT_RESET  = 16'd30;
    localparam cfg_data_t WINDOW_RESET = 16'd15;
    localparam cnt_t      FILL_FULL    = cnt_t'(TABLE_ENTRIES);

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_EXISTING = 2'd0,
        OUT_NEW      = 2'd1,
        OUT_FULL     = 2'd2,
        OUT_NO_ADDR  = 2'd3
    } outcome_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUEST_LIMIT  = 1'b0,
        REG_WINDOW_SECONDS = 1'b1
    } cfg_reg_t;

    // request payload
    typedef struct packed {
        addr_t source_address;
        logic  has_address;
        time_t now_seconds;
    } req_t;

    // result payload
    typedef struct packed {
        logic     limited;
        outcome_t outcome;
        count_t   current_count;
    } result_t;

    // one table entry as stored in memory
    typedef struct packed {
        addr_t  address;
        count_t count;
        time_t  window_start;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic scan_rd;
        logic take_hit;
        logic take_zero;
        logic claim;
        logic commit;
        logic emit_full;
        logic emit_noaddr;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_more;
        logic rd_hit;
        logic table_full;
        logic req_zero;
    } ctrl_status_t;

endpackage

[rtl/core/per_source_fixed_window_rate_limiter.sv]
// Top level of the per-source fixed-window rate limiter.
// Instantiates psfwrl_ctrl and psfwrl_datapath; uses psfwrl_pkg.
//
// A request is taken when start is high and busy is low. Its single result shows on
// result for exactly one cycle with result_valid high. The receiver cannot hold it off,
// so it must capture the result in that cycle. A request without an address is answered
// straight from idle and leaves busy low. Otherwise the block scans the filled part of the
// source table from slot 0, one memory read per cycle on the table's single read port.
// A hit ends the scan and goes through an update state to its result. Once the filled
// part is read, a full table or a new source is answered directly, and address zero goes
// through the update state unless the table is full. A hit in the last slot takes longest.
// Filled slots always form a prefix, tracked by a fill count, so the table needs no
// clearing pass after reset and is ready at once. Configuration writes on cfg_we take
// effect at the next edge and belong in idle time.
module per_source_fixed_window_rate_limiter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  psfwrl_pkg::req_t                    req,
    output logic                                result_valid,
    output psfwrl_pkg::result_t                 result,
    input  logic                                cfg_we,
    input  logic [psfwrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  psfwrl_pkg::cfg_data_t               cfg_data
);

    psfwrl_pkg::ctrl_cmd_t    cmd;
    psfwrl_pkg::ctrl_status_t status;

    // sequencer
    psfwrl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .has_address (req.has_address),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    // table, arithmetic and result registers
    psfwrl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[rtl/core/psfwrl_ctrl.sv]
// Request sequencer for the rate limiter: accepts a request, steps the table scan
// and picks the hit, claim, zero-slot, full or no-address path. Depends on psfwrl_pkg.
module psfwrl_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     has_address,
    input  psfwrl_pkg::ctrl_status_t status,
    output psfwrl_pkg::ctrl_cmd_t    cmd,
    output logic                     busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (has_address)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        cmd.emit_noaddr = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.rd_hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_UPDATE;
                end
                else if (status.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else if (status.table_full)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (status.req_zero)
                begin
                    // address zero counts against the first empty slot
                    cmd.take_zero = 1'b1;
                    state_next    = S_UPDATE;
                end
                else
                begin
                    cmd.claim  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/core/psfwrl_datapath.sv]
// Datapath of the rate limiter: source table memory, fill count, first empty slot
// counters, window and limit arithmetic, config and result registers. Uses psfwrl_pkg.
module psfwrl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psfwrl_pkg::req_t              req,
    input  psfwrl_pkg::ctrl_cmd_t         cmd,
    output psfwrl_pkg::ctrl_status_t      status,
    input  logic                          cfg_we,
    input  logic [psfwrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  psfwrl_pkg::cfg_data_t         cfg_data,
    output logic                          result_valid,
    output psfwrl_pkg::result_t           result
);

    // config registers
    psfwrl_pkg::cfg_data_t limit_reg;
    psfwrl_pkg::cfg_data_t window_reg;

    // latched request
    psfwrl_pkg::addr_t req_addr_reg;
    psfwrl_pkg::time_t req_now_reg;

    // scan and table occupancy
    psfwrl_pkg::cnt_t scan_idx_reg;
    psfwrl_pkg::cnt_t fill_reg;
    psfwrl_pkg::idx_t rd_idx_reg;
    logic             rd_valid_reg;

    // memory and its ports
    psfwrl_pkg::entry_t mem [psfwrl_pkg::TABLE_ENTRIES];
    psfwrl_pkg::entry_t rd_data_reg;
    logic               mem_we;
    psfwrl_pkg::idx_t   wr_idx;
    psfwrl_pkg::entry_t wr_data;

    // count and window of the first empty slot
    psfwrl_pkg::count_t zero_count_reg;
    psfwrl_pkg::time_t  zero_win_reg;

    // entry being updated
    psfwrl_pkg::count_t cur_count_reg;
    psfwrl_pkg::time_t  cur_win_reg;
    psfwrl_pkg::idx_t   tgt_idx_reg;
    logic               is_zero_reg;

    // update arithmetic
    psfwrl_pkg::time_t  elapsed;
    logic               expired;
    psfwrl_pkg::count_t cnt_inc;
    logic               lim_keep;
    logic               lim_restart;
    psfwrl_pkg::count_t new_count;
    psfwrl_pkg::time_t  new_win;
    logic               new_limited;

    // result registers
    logic                result_valid_reg;
    psfwrl_pkg::result_t result_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= psfwrl_pkg::LIMIT_RESET;
            window_reg <= psfwrl_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psfwrl_pkg::REG_REQUEST_LIMIT:  limit_reg  <= cfg_data;
                psfwrl_pkg::REG_WINDOW_SECONDS: window_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_addr_reg <= req.source_address;
            req_now_reg  <= req.now_seconds;
        end
    end

    // scan pointer and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_rd;
            if (cmd.load_req)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + psfwrl_pkg::cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            rd_idx_reg <= scan_idx_reg[psfwrl_pkg::IDX_W-1:0];
        end
    end

    // filled slots form a prefix, so a count replaces a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            zero_count_reg <= '0;
            zero_win_reg   <= '0;
        end
        else if (cmd.claim)
        begin
            fill_reg       <= fill_reg + psfwrl_pkg::cnt_t'(1);
            zero_count_reg <= '0;
            zero_win_reg   <= '0;
        end
        else if (cmd.commit && is_zero_reg)
        begin
            zero_count_reg <= new_count;
            zero_win_reg   <= new_win;
        end
    end

    // status to controller
    always_comb
    begin
        status.scan_more  = (scan_idx_reg < fill_reg);
        status.rd_hit     = rd_valid_reg && (rd_data_reg.address == req_addr_reg);
        status.table_full = (fill_reg == psfwrl_pkg::FILL_FULL);
        status.req_zero   = (req_addr_reg == '0);
    end

    // memory write select
    always_comb
    begin
        mem_we  = 1'b0;
        wr_idx  = tgt_idx_reg;
        wr_data = '{address: req_addr_reg, count: new_count, window_start: new_win};
        if (cmd.claim)
        begin
            mem_we  = 1'b1;
            wr_idx  = fill_reg[psfwrl_pkg::IDX_W-1:0];
            wr_data = '{address: req_addr_reg, count: psfwrl_pkg::count_t'(1),
                        window_start: req_now_reg};
        end
        else if (cmd.commit && !is_zero_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // source table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[scan_idx_reg[psfwrl_pkg::IDX_W-1:0]];
        end
    end

    // entry under update
    always_ff @(posedge clk)
    begin
        if (cmd.take_hit)
        begin
            cur_count_reg <= rd_data_reg.count;
            cur_win_reg   <= rd_data_reg.window_start;
            tgt_idx_reg   <= rd_idx_reg;
            is_zero_reg   <= 1'b0;
        end
        else if (cmd.take_zero)
        begin
            cur_count_reg <= zero_count_reg;
            cur_win_reg   <= zero_win_reg;
            is_zero_reg   <= 1'b1;
        end
    end

    // window expiry and saturating count, both limit checks side by side
    always_comb
    begin
        elapsed     = req_now_reg - cur_win_reg;
        expired     = (elapsed > {{(psfwrl_pkg::TIME_W - psfwrl_pkg::CFG_W){1'b0}}, window_reg});
        cnt_inc     = (cur_count_reg == psfwrl_pkg::COUNT_MAX) ? psfwrl_pkg::COUNT_MAX
                                                               : cur_count_reg + 16'd1;
        lim_keep    = (cnt_inc > limit_reg);
        lim_restart = (limit_reg == '0);
        new_count   = expired ? psfwrl_pkg::count_t'(1) : cnt_inc;
        new_win     = expired ? req_now_reg : cur_win_reg;
        new_limited = expired ? lim_restart : lim_keep;
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.commit || cmd.claim || cmd.emit_full || cmd.emit_noaddr;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= '{limited: new_limited, outcome: psfwrl_pkg::OUT_EXISTING,
                            current_count: new_count};
        end
        else if (cmd.claim)
        begin
            result_reg <= '{limited: 1'b0, outcome: psfwrl_pkg::OUT_NEW,
                            current_count: psfwrl_pkg::count_t'(1)};
        end
        else if (cmd.emit_full)
        begin
            result_reg <= '{limited: 1'b0, outcome: psfwrl_pkg::OUT_FULL,
                            current_count: '0};
        end
        else if (cmd.emit_noaddr)
        begin
            result_reg <= '{limited: 1'b0, outcome: psfwrl_pkg::OUT_NO_ADDR,
                            current_count: '0};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the per-source fixed-window rate limiter.
// Drives requests and limit/window writes, predicts every decision with its own
// source table model and checks each result; depends on psfwrl_pkg and the top level.
module tb_top;
    import psfwrl_pkg::*;

    // one row of the directed plan: a register setting or a request
    typedef struct {
        logic      is_cfg;
        cfg_data_t lim;
        cfg_data_t win;
        req_t      rq;
        logic      typed;
        result_t   want;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    req_t                    req = '0;
    logic                    result_valid;
    result_t                 result;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    cfg_data_t               cfg_data = '0;

    // expectation typed into the plan, travels with the request
    logic                    use_typed = 1'b0;
    result_t                 typed_want = '0;

    // predictor state: source table and register copies
    addr_t                   src_addr [TABLE_ENTRIES];
    count_t                  src_count [TABLE_ENTRIES];
    time_t                   src_window_start [TABLE_ENTRIES];
    cfg_data_t               limit_now;
    cfg_data_t               window_now;

    result_t                 pending_decisions [$];
    addr_t                   known_sources [32];
    plan_row_t               directed_plan [$];
    time_t                   clock_sec;
    int                      errors = 0;
    int                      checked = 0;
    int                      n_limited = 0;
    int                      n_settings = 0;
    int                      outcome_seen [0:3] = '{0, 0, 0, 0};

    per_source_fixed_window_rate_limiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // scan the table in slot order: a match is tested before an empty slot
    function automatic result_t decide_request(req_t rq);
        result_t res;
        logic    done;
        res.limited = 1'b0;
        res.outcome = OUT_FULL;
        res.current_count = '0;
        done = 1'b0;
        if (!rq.has_address)
        begin
            res.outcome = OUT_NO_ADDR;
        end
        else
        begin
            for (int slot = 0; slot < TABLE_ENTRIES && !done; slot++)
            begin
                if (src_addr[slot] == rq.source_address)
                begin
                    // window elapsed: unsigned wrapped difference past the window
                    if (time_t'(rq.now_seconds - src_window_start[slot]) > time_t'(window_now))
                    begin
                        src_count[slot] = '0;
                        src_window_start[slot] = rq.now_seconds;
                    end
                    if (src_count[slot] != COUNT_MAX)
                        src_count[slot] = src_count[slot] + 1'b1;
                    res.outcome = OUT_EXISTING;
                    res.current_count = src_count[slot];
                    res.limited = (src_count[slot] > limit_now);
                    done = 1'b1;
                end
                else if (src_addr[slot] == '0)
                begin
                    src_addr[slot] = rq.source_address;
                    src_count[slot] = 16'd1;
                    src_window_start[slot] = rq.now_seconds;
                    res.outcome = OUT_NEW;
                    res.current_count = 16'd1;
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // predict on every accepted transfer, check every result against the oldest one
    always @(posedge clk)
    begin
        result_t want;
        result_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                src_addr[i] = '0;
                src_count[i] = '0;
                src_window_start[i] = '0;
            end
            limit_now = LIMIT_RESET;
            window_now = WINDOW_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_REQUEST_LIMIT:  limit_now = cfg_data;
                    REG_WINDOW_SECONDS: window_now = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                pred = decide_request(req);
                pending_decisions.push_back(use_typed ? typed_want : pred);
            end
            if (result_valid)
            begin
                if (pending_decisions.size() == 0)
                begin
                    $error("result transfer with no request pending");
                    errors++;
                end
                else
                begin
                    want = pending_decisions.pop_front();
                    if (result.limited !== want.limited)
                    begin
                        $error("limited: expected %0d, got %0d", want.limited, result.limited);
                        errors++;
                    end
                    if (result.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, result.outcome);
                        errors++;
                    end
                    if (result.current_count !== want.current_count)
                    begin
                        $error("current_count: expected %0d, got %0d",
                               want.current_count, result.current_count);
                        errors++;
                    end
                    checked++;
                    n_limited += result.limited;
                    outcome_seen[result.outcome]++;
                end
            end
        end
    end

    // hold start high until the transfer is taken
    task automatic send_request(input req_t rq, input logic typed, input result_t want);
        start <= 1'b1;
        req <= rq;
        use_typed <= typed;
        typed_want <= want;
        @(posedge clk);
        while (!(start && !busy))
            @(posedge clk);
    endtask

    // drain all decisions, then write both registers on consecutive edges
    task automatic write_limits(input cfg_data_t lim, input cfg_data_t win);
        start <= 1'b0;
        @(posedge clk);
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_REQUEST_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_index <= REG_WINDOW_SECONDS;
        cfg_data <= win;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic plan_row_t cfg_row(cfg_data_t lim, cfg_data_t win);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.lim = lim;
        r.win = win;
        r.rq = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t req_row(addr_t a, logic has, time_t t, int typed,
                                          int lim, outcome_t oc, int cnt);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.lim = '0;
        r.win = '0;
        r.rq.source_address = a;
        r.rq.has_address = has;
        r.rq.now_seconds = t;
        r.typed = 1'(typed);
        r.want.limited = 1'(lim);
        r.want.outcome = oc;
        r.want.current_count = count_t'(cnt);
        return r;
    endfunction

    // random requests: pool sources for repeats, fresh ones to fill the table
    task automatic run_phase(input int n_items, input int idle_pct, input int win,
                             input int fresh_pct);
        req_t    rq;
        req_t    junk;
        result_t none;
        int      kind;
        int      burst_left;
        none = '0;
        burst_left = 0;
        for (int k = 0; k < n_items; k++)
        begin
            // sender gaps, with occasional back-to-back stretches
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(99) < 4)
                burst_left = 20;
            else
            begin
                while ($urandom_range(99) < idle_pct)
                begin
                    junk.source_address = $urandom;
                    junk.has_address = 1'($urandom_range(1));
                    junk.now_seconds = $urandom;
                    start <= 1'b0;
                    req <= junk;
                    @(posedge clk);
                end
            end
            // time mostly creeps forward, sometimes jumps or sits near the wrap
            kind = $urandom_range(99);
            if (kind < 60)
                clock_sec += time_t'($urandom_range(2));
            else if (kind < 82)
                clock_sec += time_t'($urandom_range(win + 2));
            else if (kind < 92)
                clock_sec = time_t'($urandom);
            else
                clock_sec = 32'hFFFF_FFFF - time_t'($urandom_range(6));
            rq.now_seconds = clock_sec;
            rq.has_address = 1'b1;
            kind = $urandom_range(99);
            if (kind < 7)
            begin
                rq.has_address = 1'b0;
                rq.source_address = $urandom;
            end
            else if (kind < 11)
                rq.source_address = '0;
            else if (kind < 11 + fresh_pct)
                rq.source_address = $urandom;
            else
                rq.source_address = known_sources[$urandom_range(31)];
            send_request(rq, 1'b0, none);
        end
    endtask

    // generous bound on the whole run
    initial
    begin
        #60_000_000;
        $display("[per_source_fixed_window_rate_limiter] ERROR");
        $finish;
    end

    initial
    begin
        result_t none;
        req_t    sat_req;
        int      guard;
        none = '0;
        known_sources[0] = 32'hFFFF_FFFF;
        known_sources[1] = 32'h8000_0000;
        known_sources[2] = 32'h0000_0001;
        for (int i = 3; i < 32; i++)
            known_sources[i] = $urandom | 32'h0000_0100;
        clock_sec = $urandom;

        // reset values first, then window edges, wrap, address zero and both extremes
        directed_plan.push_back(req_row(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1, 0, OUT_NO_ADDR, 0));
        directed_plan.push_back(req_row(32'h0A00_0001, 1'b1, 32'd100, 1, 0, OUT_NEW, 1));
        directed_plan.push_back(req_row(32'h0A00_0001, 1'b1, 32'd100, 1, 0, OUT_EXISTING, 2));
        directed_plan.push_back(req_row(32'h0A00_0001, 1'b1, 32'd115, 1, 0, OUT_EXISTING, 3));
        directed_plan.push_back(req_row(32'h0A00_0001, 1'b1, 32'd116, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(cfg_row(16'd1, 16'd15));
        directed_plan.push_back(req_row(32'h0A00_0001, 1'b1, 32'd116, 1, 1, OUT_EXISTING, 2));
        directed_plan.push_back(req_row(32'hFFFF_FFFF, 1'b1, 32'd0, 1, 0, OUT_NEW, 1));
        directed_plan.push_back(req_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(req_row(32'hFFFF_FFFF, 1'b1, 32'd5, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(req_row(32'h0000_0000, 1'b1, 32'd7, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(req_row(32'h0000_0000, 1'b1, 32'd8, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(req_row(32'h0000_0001, 1'b1, 32'd9, 1, 0, OUT_NEW, 1));
        directed_plan.push_back(cfg_row(16'd0, 16'd0));
        directed_plan.push_back(req_row(32'h0000_0001, 1'b1, 32'd9, 1, 1, OUT_EXISTING, 2));
        directed_plan.push_back(req_row(32'h0000_0001, 1'b1, 32'd10, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(cfg_row(16'hFFFF, 16'hFFFF));
        directed_plan.push_back(req_row(32'h8000_0000, 1'b0, 32'h8000_0000, 1, 0, OUT_NO_ADDR, 0));
        directed_plan.push_back(req_row(32'h8000_0000, 1'b1, 32'h8000_0000, 1, 0, OUT_NEW, 1));
        directed_plan.push_back(req_row(32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 0, 0, OUT_EXISTING, 0));
        directed_plan.push_back(req_row(32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 1, 0, OUT_NEW, 1));
        directed_plan.push_back(req_row(32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 1, 0, OUT_NEW, 1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
                write_limits(directed_plan[i].lim, directed_plan[i].win);
            else
                send_request(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);
        end

        // one source hammered inside a long window well past its limit
        write_limits(16'd20, 16'hFFFF);
        sat_req.source_address = 32'h0A00_0001;
        sat_req.has_address = 1'b1;
        sat_req.now_seconds = 32'd200;
        for (int k = 0; k < 40; k++)
            send_request(sat_req, 1'b0, none);

        // random phases under different settings and sender idle rates
        write_limits(16'd2, 16'd10);
        run_phase(200, 0, 10, 15);
        write_limits(16'd0, 16'd0);
        run_phase(200, 85, 0, 20);
        write_limits(16'hFFFF, 16'hFFFF);
        run_phase(150, 38, 65535, 20);
        begin
            cfg_data_t w;
            w = cfg_data_t'($urandom_range(40));
            write_limits(cfg_data_t'($urandom), w);
            run_phase(250, 85, int'(w), 60);
        end
        write_limits(16'd5, 16'd3);
        run_phase(200, 0, 3, 30);

        // drain and let the block settle
        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending_decisions.size() != 0 && guard < 4 * TABLE_ENTRIES)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (pending_decisions.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_decisions.size());
            errors++;
        end

        $display("checked %0d decisions: %0d counted, %0d new, %0d table full, %0d no address",
                 checked, outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
        $display("%0d limited, over %0d limit/window settings and sender idle of 0/38/85 pct",
                 n_limited, n_settings);
        if (errors == 0)
            $display("[per_source_fixed_window_rate_limiter] OK");
        else
            $display("[per_source_fixed_window_rate_limiter] ERROR");
        $finish;
    end

endmodule
